>>> hdl/lkci_pkg.sv
// ----------------------------------------------------------------------------
// LED/key command interface package
// Shared types, codes and constants of the LED/key command interface.
// ----------------------------------------------------------------------------
`default_nettype none

package lkci_pkg;

   localparam int RAM_DEPTH = 16;
   localparam int KEY_BYTES = 4;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_STROBE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_INVALID = 2'd0,
      CMD_DATA    = 2'd1,
      CMD_DISPLAY = 2'd2,
      CMD_ADDRESS = 2'd3
   } cmd_kind_type;

   localparam logic [7:0] DATA_BAD_MASK   = 8'h39;
   localparam logic [7:0] DATA_READ_BIT   = 8'h02;
   localparam logic [7:0] DATA_FIXED_BIT  = 8'h04;
   localparam logic [7:0] DISPLAY_ON_BIT  = 8'h08;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic [23:0] key_matrix;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_error;
      logic       ram_write_valid;
      logic [3:0] ram_write_addr;
      logic [7:0] ram_write_data;
      logic       display_on;
      logic [2:0] brightness;
      logic       command_error;
   } rsp_type;

   // Key byte i carries scan line 2i in bits 0..2 and scan line 2i+1 in bits 4..6.
   function automatic logic [7:0] key_byte(input logic [23:0] km, input logic [1:0] idx);
      logic [5:0] lines;
      case (idx)
         2'd0:    lines = km[5:0];
         2'd1:    lines = km[11:6];
         2'd2:    lines = km[17:12];
         default: lines = km[23:18];
      endcase
      return {1'b0, lines[5:3], 1'b0, lines[2:0]};
   endfunction

endpackage

`default_nettype wire

>>> hdl/lkci_if.sv
// ----------------------------------------------------------------------------
// LED/key command interface channels
// Valid/ready channels for request and response transfers.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkci_req_if;
   logic              valid;
   logic              ready;
   lkci_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lkci_rsp_if;
   logic              valid;
   logic              ready;
   lkci_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/led_keyscan_command_interface_unit.sv
// ----------------------------------------------------------------------------
// LED/key command interface unit
// Device side of a strobe-framed serial LED driver with key scan.
//
// Each request transfer carries one event: a byte written inside a frame,
// the strobe ending a frame, or the host clocking out one key byte. Each
// request yields exactly one response transfer with the key read result,
// any display RAM write, the display state after the event and error flags.
// The request is held in an input register; the decoder and state update
// sit between it and the response register, from which the response is
// offered. One request is taken every cycle as long as the receiver keeps
// up. When the receiver stalls, the response register holds, then the
// input register fills, and after that the request channel stops taking
// transfers until the stall ends.
// Synchronous reset empties both registers and returns the frame state to
// the start of a frame with the display off and brightness zero.
// ----------------------------------------------------------------------------
`default_nettype none

module led_keyscan_command_interface_unit (
   input wire logic  clock,
   input wire logic  reset,
   lkci_req_if.sink  req_chan,
   lkci_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   lkci_pkg::req_type in_item_ff;
   logic              out_valid_ff;
   lkci_pkg::rsp_type out_item_ff;
   lkci_pkg::rsp_type result;
   logic              advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   lkci_cmd_decoder decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

endmodule

`default_nettype wire

>>> hdl/lkci_cmd_decoder.sv
// ----------------------------------------------------------------------------
// LED/key command decoder
// Holds the frame state and turns one registered request into one response.
// ----------------------------------------------------------------------------
`default_nettype none

module lkci_cmd_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire lkci_pkg::req_type item,
   output lkci_pkg::rsp_type      result
);

   logic [3:0] address_pointer_ff, address_pointer_in;
   logic       frame_first_ff, frame_first_in;
   logic       fixed_mode_ff, fixed_mode_in;
   logic       read_mode_ff, read_mode_in;
   logic       address_loaded_ff, address_loaded_in;
   logic [2:0] read_index_ff, read_index_in;
   logic       display_enable_ff, display_enable_in;
   logic [2:0] brightness_ff, brightness_in;

   always_comb begin
      address_pointer_in = address_pointer_ff;
      frame_first_in     = frame_first_ff;
      fixed_mode_in      = fixed_mode_ff;
      read_mode_in       = read_mode_ff;
      address_loaded_in  = address_loaded_ff;
      read_index_in      = read_index_ff;
      display_enable_in  = display_enable_ff;
      brightness_in      = brightness_ff;
      result             = '0;

      case (lkci_pkg::opcode_type'(item.opcode))
         lkci_pkg::OP_WRITE: begin
            if (frame_first_ff) begin
               frame_first_in = 1'b0;
               case (lkci_pkg::cmd_kind_type'(item.data_byte[7:6]))
                  lkci_pkg::CMD_DATA: begin
                     if ((item.data_byte & lkci_pkg::DATA_BAD_MASK) != 8'h00) begin
                        result.command_error = 1'b1;
                     end else if ((item.data_byte & lkci_pkg::DATA_READ_BIT) != 8'h00) begin
                        read_mode_in  = 1'b1;
                        read_index_in = '0;
                     end else begin
                        fixed_mode_in = (item.data_byte & lkci_pkg::DATA_FIXED_BIT) != 8'h00;
                     end
                  end
                  lkci_pkg::CMD_DISPLAY: begin
                     display_enable_in =
                        (item.data_byte & lkci_pkg::DISPLAY_ON_BIT) != 8'h00;
                     brightness_in = item.data_byte[2:0];
                  end
                  lkci_pkg::CMD_ADDRESS: begin
                     address_pointer_in = item.data_byte[3:0];
                     address_loaded_in  = 1'b1;
                  end
                  default: begin
                     result.command_error = 1'b1;
                  end
               endcase
            end else if (address_loaded_ff && !read_mode_ff) begin
               if ({1'b0, address_pointer_ff} < 5'(lkci_pkg::RAM_DEPTH)) begin
                  result.ram_write_valid = 1'b1;
                  result.ram_write_addr  = address_pointer_ff;
                  result.ram_write_data  = item.data_byte;
               end
               if (!fixed_mode_ff) begin
                  address_pointer_in = address_pointer_ff + 4'd1;
               end
            end
         end
         lkci_pkg::OP_STROBE: begin
            frame_first_in    = 1'b1;
            address_loaded_in = 1'b0;
            read_mode_in      = 1'b0;
            read_index_in     = '0;
         end
         lkci_pkg::OP_READ: begin
            if (read_mode_ff && (read_index_ff < 3'(lkci_pkg::KEY_BYTES))) begin
               result.read_data  = lkci_pkg::key_byte(item.key_matrix, read_index_ff[1:0]);
               result.read_valid = 1'b1;
               read_index_in     = read_index_ff + 3'd1;
            end else begin
               result.read_error = 1'b1;
            end
         end
         default: begin
         end
      endcase

      result.display_on = display_enable_in;
      result.brightness = brightness_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_pointer_ff <= '0;
         frame_first_ff     <= 1'b1;
         fixed_mode_ff      <= 1'b0;
         read_mode_ff       <= 1'b0;
         address_loaded_ff  <= 1'b0;
         read_index_ff      <= '0;
         display_enable_ff  <= 1'b0;
         brightness_ff      <= '0;
      end else if (step) begin
         address_pointer_ff <= address_pointer_in;
         frame_first_ff     <= frame_first_in;
         fixed_mode_ff      <= fixed_mode_in;
         read_mode_ff       <= read_mode_in;
         address_loaded_ff  <= address_loaded_in;
         read_index_ff      <= read_index_in;
         display_enable_ff  <= display_enable_in;
         brightness_ff      <= brightness_in;
      end
   end

endmodule

`default_nettype wire
